// ===== design/bls_pkg.sv =====
// Shared types and constants of the line stepper.
`default_nettype none
package bls_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_STEP  = 1'b1
  } kind_e;

endpackage
`default_nettype wire

// ===== design/bls_step.sv =====
// Line state registers and combinational start/step point calculation.
`default_nettype none
module bls_step #(
  parameter int unsigned COORD_BITS = 16
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         accept_i,
  input  bls_pkg::kind_e              kind_i,
  input  wire signed [COORD_BITS-1:0] x_start_i,
  input  wire signed [COORD_BITS-1:0] y_start_i,
  input  wire signed [COORD_BITS-1:0] x_end_i,
  input  wire signed [COORD_BITS-1:0] y_end_i,
  output logic                        res_valid_o,
  output logic [COORD_BITS-1:0]       res_x_o,
  output logic [COORD_BITS-1:0]       res_y_o,
  output logic                        res_last_o
);
  import bls_pkg::*;

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned EW = COORD_BITS + 3;

  logic                  active_q, active_d;
  logic                  steep_q, steep_d;
  logic [COORD_BITS-1:0] major_pos_q, major_pos_d;
  logic [COORD_BITS-1:0] minor_pos_q, minor_pos_d;
  logic [COORD_BITS-1:0] major_end_q, major_end_d;
  logic                  major_dir_q, major_dir_d;
  logic                  minor_dir_q, minor_dir_d;
  logic [DW-1:0]         abs_major_q, abs_major_d;
  logic [DW-1:0]         abs_minor_q, abs_minor_d;
  logic signed [EW-1:0]  error_acc_q, error_acc_d;

  logic signed [DW-1:0]  dx, dy;
  logic [DW-1:0]         abs_dx, abs_dy;
  logic                  steep_new;
  logic signed [EW-1:0]  err_sum, err_sub, major_ext;
  logic                  last;

  always_comb begin
    dx = DW'(x_end_i) - DW'(x_start_i);
    dy = DW'(y_end_i) - DW'(y_start_i);
    abs_dx = dx[DW-1] ? DW'(-dx) : DW'(dx);
    abs_dy = dy[DW-1] ? DW'(-dy) : DW'(dy);
    steep_new = (dx == '0) || (abs_dy > abs_dx);

    major_ext = $signed({2'b00, abs_major_q});
    err_sum   = error_acc_q + $signed({1'b0, abs_minor_q, 1'b0});
    err_sub   = err_sum - $signed({1'b0, abs_major_q, 1'b0});

    active_d    = active_q;
    steep_d     = steep_q;
    major_pos_d = major_pos_q;
    minor_pos_d = minor_pos_q;
    major_end_d = major_end_q;
    major_dir_d = major_dir_q;
    minor_dir_d = minor_dir_q;
    abs_major_d = abs_major_q;
    abs_minor_d = abs_minor_q;
    error_acc_d = error_acc_q;
    res_valid_o = 1'b0;

    if (accept_i && kind_i == KIND_START) begin
      steep_d     = steep_new;
      error_acc_d = '0;
      active_d    = 1'b1;
      res_valid_o = 1'b1;
      if (steep_new) begin
        major_pos_d = y_start_i;
        major_end_d = y_end_i;
        minor_pos_d = x_start_i;
        major_dir_d = dy[DW-1];
        minor_dir_d = dx[DW-1];
        abs_major_d = abs_dy;
        abs_minor_d = abs_dx;
      end else begin
        major_pos_d = x_start_i;
        major_end_d = x_end_i;
        minor_pos_d = y_start_i;
        major_dir_d = dx[DW-1];
        minor_dir_d = dy[DW-1];
        abs_major_d = abs_dx;
        abs_minor_d = abs_dy;
      end
    end else if (accept_i && active_q) begin
      res_valid_o = 1'b1;
      if (err_sum >= major_ext) begin
        minor_pos_d = minor_dir_q ? minor_pos_q - 1'b1 : minor_pos_q + 1'b1;
        error_acc_d = err_sub;
      end else begin
        error_acc_d = err_sum;
      end
      major_pos_d = major_dir_q ? major_pos_q - 1'b1 : major_pos_q + 1'b1;
    end

    last = (major_pos_d == major_end_d);
    if (res_valid_o && last) begin
      active_d = 1'b0;
    end
    res_last_o = last;
    res_x_o    = steep_d ? minor_pos_d : major_pos_d;
    res_y_o    = steep_d ? major_pos_d : minor_pos_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      steep_q     <= 1'b0;
      major_pos_q <= '0;
      minor_pos_q <= '0;
      major_end_q <= '0;
      major_dir_q <= 1'b0;
      minor_dir_q <= 1'b0;
      abs_major_q <= '0;
      abs_minor_q <= '0;
      error_acc_q <= '0;
    end else begin
      active_q    <= active_d;
      steep_q     <= steep_d;
      major_pos_q <= major_pos_d;
      minor_pos_q <= minor_pos_d;
      major_end_q <= major_end_d;
      major_dir_q <= major_dir_d;
      minor_dir_q <= minor_dir_d;
      abs_major_q <= abs_major_d;
      abs_minor_q <= abs_minor_d;
      error_acc_q <= error_acc_d;
    end
  end

endmodule
`default_nettype wire

// ===== design/bls_out_reg.sv =====
// Output register holding one point until the receiver takes it.
`default_nettype none
module bls_out_reg #(
  parameter int unsigned DATA_BITS = 32
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  load_i,
  input  wire [DATA_BITS-1:0]  data_i,
  input  wire                  last_i,
  output logic                 ready_o,
  output logic                 valid_o,
  output logic [DATA_BITS-1:0] data_o,
  output logic                 last_o,
  input  wire                  ready_i
);
  logic                 valid_q, valid_d;
  logic [DATA_BITS-1:0] data_q;
  logic                 last_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      data_q <= data_i;
      last_q <= last_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign last_o  = last_q;

endmodule
`default_nettype wire

// ===== design/bresenham_line_stepper_top.sv =====
// Top level of the Bresenham line stepper.
//
// Slave stream: tuser is the item kind (start or step), tdata carries the
// endpoints. A start transfer loads the line and yields its first point; each
// step transfer yields the next point. The end point comes with tlast high;
// step transfers after it, or before any start, are taken and yield nothing.
// A start transfer always abandons a line in progress.
// Master stream: tdata carries the point, tlast marks the end point.
// Each point is registered and shows on the master side in the cycle after
// its input transfer; one item is taken per cycle, set by the combinational
// state update and the output register. When the receiver stalls, the output
// register holds the point and s_axis_tready drops until the point is taken.
// Reset clears the line state (no line loaded) and empties the output
// register.
`default_nettype none
module bresenham_line_stepper_top #(
  parameter int unsigned COORD_BITS = bls_pkg::COORD_BITS_DEF,
  localparam int unsigned IN_BITS  = ((4 * COORD_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_BITS = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 s_axis_tvalid,
  output logic                s_axis_tready,
  input  wire [IN_BITS-1:0]   s_axis_tdata,  // x_start, y_start, x_end, y_end, zero fill
  input  wire                 s_axis_tuser,  // kind
  output logic                m_axis_tvalid,
  input  wire                 m_axis_tready,
  output logic [OUT_BITS-1:0] m_axis_tdata,  // x, y, zero fill
  output logic                m_axis_tlast
);
  import bls_pkg::*;

  logic                  accept;
  kind_e                 kind;
  logic                  res_valid;
  logic [COORD_BITS-1:0] res_x, res_y;
  logic                  res_last;
  logic [OUT_BITS-1:0]   res_data;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign kind   = kind_e'(s_axis_tuser);

  bls_step #(
    .COORD_BITS(COORD_BITS)
  ) u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .kind_i     (kind),
    .x_start_i  (s_axis_tdata[COORD_BITS-1:0]),
    .y_start_i  (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .x_end_i    (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .y_end_i    (s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS]),
    .res_valid_o(res_valid),
    .res_x_o    (res_x),
    .res_y_o    (res_y),
    .res_last_o (res_last)
  );

  assign res_data = OUT_BITS'({res_y, res_x});

  bls_out_reg #(
    .DATA_BITS(OUT_BITS)
  ) u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (res_valid),
    .data_i (res_data),
    .last_i (res_last),
    .ready_o(s_axis_tready),
    .valid_o(m_axis_tvalid),
    .data_o (m_axis_tdata),
    .last_o (m_axis_tlast),
    .ready_i(m_axis_tready)
  );

endmodule
`default_nettype wire

// ===== tb/sv/bresenham_line_stepper_top_test.sv =====
// Stream-level test of the line stepper against a cycle-free line predictor.
module bresenham_line_stepper_top_test;
  import bls_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 20000;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               last;
  } point_t;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = KIND_START;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned failures       = 0;
  int unsigned items_sent     = 0;
  int unsigned lines_started  = 0;
  int unsigned points_checked = 0;
  int unsigned quiet_cycles   = 0;

  point_t pending_points[$];

  logic               line_active;
  logic               line_steep;
  logic signed [15:0] major_at;
  logic signed [15:0] minor_at;
  logic signed [15:0] major_stop;
  logic               major_down;
  logic               minor_down;
  logic        [16:0] major_span;
  logic        [16:0] minor_span;
  logic signed [18:0] bres_err;

  bresenham_line_stepper_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic void clear_line();
    line_active = 1'b0;
    line_steep  = 1'b0;
    major_at    = '0;
    minor_at    = '0;
    major_stop  = '0;
    major_down  = 1'b0;
    minor_down  = 1'b0;
    major_span  = '0;
    minor_span  = '0;
    bres_err    = '0;
  endfunction

  // Advance the line by one transfer; report whether it yields a point.
  function automatic void next_point(input kind_e kind, input logic [63:0] data,
                                     output logic yields, output point_t pt);
    logic signed [15:0] xs, ys, xe, ye;
    logic signed [16:0] dx, dy;
    logic        [16:0] adx, ady;
    xs = data[15:0];
    ys = data[31:16];
    xe = data[47:32];
    ye = data[63:48];
    pt = '0;
    yields = 1'b0;
    if (kind == KIND_START) begin
      dx  = xe - xs;
      dy  = ye - ys;
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      line_steep = (dx == 0) || (ady > adx);
      if (line_steep) begin
        major_at   = ys;
        major_stop = ye;
        minor_at   = xs;
        major_down = (dy < 0);
        minor_down = (dx < 0);
        major_span = ady;
        minor_span = adx;
      end else begin
        major_at   = xs;
        major_stop = xe;
        minor_at   = ys;
        major_down = (dx < 0);
        minor_down = (dy < 0);
        major_span = adx;
        minor_span = ady;
      end
      bres_err    = '0;
      line_active = 1'b1;
    end else if (line_active) begin
      bres_err = bres_err + $signed({1'b0, minor_span, 1'b0});
      if (bres_err >= $signed({2'b00, major_span})) begin
        minor_at = minor_down ? minor_at - 16'sd1 : minor_at + 16'sd1;
        bres_err = bres_err - $signed({1'b0, major_span, 1'b0});
      end
      major_at = major_down ? major_at - 16'sd1 : major_at + 16'sd1;
    end else begin
      return;
    end
    yields  = 1'b1;
    pt.x    = line_steep ? minor_at : major_at;
    pt.y    = line_steep ? major_at : minor_at;
    pt.last = (major_at == major_stop);
    if (pt.last) line_active = 1'b0;
  endfunction

  // Check each output transfer, then predict from each input transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    point_t want;
    point_t pt;
    logic   yields;
    if (!rst_ni) begin
      clear_line();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_points.size() == 0) begin
          $error("point (%0d, %0d) last %0b with none expected",
                 $signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[31:16]), m_axis_tlast);
          failures++;
        end else begin
          want = pending_points.pop_front();
          points_checked++;
          if (m_axis_tdata[15:0] !== want.x) begin
            $error("x: expected %0d, got %0d", want.x, $signed(m_axis_tdata[15:0]));
            failures++;
          end
          if (m_axis_tdata[31:16] !== want.y) begin
            $error("y: expected %0d, got %0d", want.y, $signed(m_axis_tdata[31:16]));
            failures++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
            failures++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        next_point(kind_e'(s_axis_tuser), s_axis_tdata, yields, pt);
        if (yields) pending_points.push_back(pt);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input kind_e kind, input logic [63:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic send_start(input int xs, input int ys, input int xe, input int ye);
    lines_started++;
    send_item(KIND_START, {16'(ye), 16'(xe), 16'(ys), 16'(xs)});
  endtask

  task automatic send_step();
    send_item(KIND_STEP, {$urandom, $urandom});
  endtask

  // Hold the sender until every expected point has been taken.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic int pick_coord();
    case ($urandom_range(9))
      0:       return -32768;
      1:       return 32767;
      default: return $signed(16'($urandom));
    endcase
  endfunction

  function automatic int offset_coord(input int base, input int delta);
    int v;
    v = base + delta;
    if (v > 32767 || v < -32768) return base - delta;
    return v;
  endfunction

  task automatic test_step_when_idle();
    send_step();
    send_step();
    drain();
  endtask

  task automatic test_zero_length();
    send_start(5, 5, 5, 5);
    send_step();
    send_start(-32768, 32767, -32768, 32767);
    drain();
  endtask

  task automatic test_full_range_restart();
    send_start(-32768, -32768, 32767, 32767);
    send_step();
    send_step();
    send_start(32767, 32767, -32768, -32768);
    send_step();
    send_step();
    send_start(-32768, 32767, 32767, -32768);
    send_step();
    drain();
  endtask

  task automatic test_axis_aligned();
    send_start(0, -32768, 0, 32767);
    send_step();
    send_start(32767, 0, 32765, 0);
    repeat (3) send_step();
    send_start(0, 0, 2, 5);
    repeat (5) send_step();
    drain();
  endtask

  task automatic test_random_lines(input int unsigned idle_pct, input int unsigned stall_pct,
                                   input int unsigned quota);
    int unsigned stop_at;
    int xs, ys, xe, ye, span, steps, limit;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      if ($urandom_range(9) == 0) send_step();
      limit = ($urandom_range(9) == 0) ? 200 : 15;
      xs = pick_coord();
      ys = pick_coord();
      xe = offset_coord(xs, $urandom_range(2 * limit) - limit);
      ye = offset_coord(ys, $urandom_range(2 * limit) - limit);
      send_start(xs, ys, xe, ye);
      span  = ((xe > xs) ? xe - xs : xs - xe);
      steps = ((ye > ys) ? ye - ys : ys - ye);
      if (steps > span) span = steps;
      steps = ($urandom_range(6) == 0) ? $urandom_range(span) : span + $urandom_range(2);
      repeat (steps) send_step();
    end
    drain();
    recv_stall_pct = 0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_step_when_idle();
    test_zero_length();
    test_full_range_restart();
    test_axis_aligned();
    test_random_lines(0, 0, 350);
    test_random_lines(76, 0, 350);
    test_random_lines(0, 76, 350);
    test_random_lines(9, 9, 350);
    $display("Sent %0d transfers over %0d lines; checked %0d points.",
             items_sent, lines_started, points_checked);
    $display("Covered idle and restart steps, zero-length, axis-aligned and full-range lines.");
    if (failures == 0 && pending_points.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/bls_pkg.sv
design/bls_step.sv
design/bls_out_reg.sv
design/bresenham_line_stepper_top.sv
tb/sv/bresenham_line_stepper_top_test.sv
